// ===== design/bvf_pkg.sv =====
// Shared types, widths, register indexes and helper functions for the body
// velocity/friction step core. No dependencies.
package bvf_pkg;

    // field widths
    localparam int VAL_W   = 32;   // Q16.16 signed values
    localparam int DT_W    = 16;   // Q0.16 time step
    localparam int FRIC_W  = 31;   // Q15.16 unsigned friction
    localparam int FRAC_W  = 16;   // fraction bits of the value format

    // serial multiplier lane
    localparam int MA_W    = VAL_W + 1;          // signed multiplicand
    localparam int MB_W    = VAL_W;              // unsigned multiplier, msb first
    localparam int MP_W    = MA_W + MB_W;        // product
    localparam int MCNT_W  = $clog2(MB_W + 1);

    // square root and divider
    localparam int RAD_W   = 2 * VAL_W;          // radicand and dividend
    localparam int ROOT_W  = VAL_W;              // root, divisor and quotient
    localparam int SCNT_W  = $clog2(ROOT_W + 1);

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION  = 2'd3;

    // command to a multiplier lane
    typedef struct packed {
        logic start;
        logic full;     // all multiplier bits, else only the upper half
    } mul_cmd_t;

    // status of a serial unit
    typedef struct packed {
        logic busy;
        logic done;     // one-cycle pulse, result valid from here on
    } unit_stat_t;

    // signed add with saturation to the 32-bit range
    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1])
            return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        else
            return s[VAL_W-1:0];
    endfunction

    // magnitude of a signed value, unsigned result
    function automatic logic [VAL_W-1:0] mag(input logic signed [VAL_W-1:0] v)
    ;
        return v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
    endfunction

endpackage

// ===== design/bvf_mul.sv =====
// Bit-serial shift-add multiplier lane: signed multiplicand times unsigned
// multiplier, one multiplier bit per cycle, msb first. Uses bvf_pkg.
module bvf_mul import bvf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mul_cmd_t                cmd,
    input  logic signed [MA_W-1:0]  a,
    input  logic        [MB_W-1:0]  b,
    output unit_stat_t              stat,
    output logic signed [MP_W-1:0]  prod
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [MCNT_W-1:0]      cnt_reg, cnt_next;
    logic signed [MA_W-1:0] a_reg;
    logic [MB_W-1:0]        b_reg;
    logic signed [MP_W-1:0] acc_reg, acc_next;
    logic signed [MP_W-1:0] addend;

    // one shift-add step
    always_comb
    begin
        addend   = b_reg[MB_W-1] ? {{(MP_W-MA_W){a_reg[MA_W-1]}}, a_reg} : '0;
        acc_next = (acc_reg <<< 1) + addend;
    end

    // step counter
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cmd.full ? MCNT_W'(MB_W) : MCNT_W'(MB_W / 2);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and accumulator registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= b_reg << 1;
            acc_reg <= acc_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

endmodule

// ===== design/bvf_sqrt.sv =====
// Digit-by-digit integer square root, two radicand bits and one root bit per
// cycle, giving floor(sqrt(radicand)) exactly. Uses bvf_pkg.
module bvf_sqrt import bvf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output unit_stat_t        stat,
    output logic [ROOT_W-1:0] root
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [SCNT_W-1:0]   cnt_reg, cnt_next;
    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W+1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W+3:0]   rem_sh;
    logic [ROOT_W+3:0]   trial;
    logic                ge;

    // one root digit: trial subtract of 4*root + 1
    always_comb
    begin
        rem_sh   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial    = {2'b00, root_reg, 2'b01};
        ge       = (rem_sh >= trial);
        rem_next = ge ? (ROOT_W+2)'(rem_sh - trial) : rem_sh[ROOT_W+1:0];
    end

    // step counter
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = SCNT_W'(ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // radicand, remainder and root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

// ===== design/bvf_div.sv =====
// Restoring divider, one quotient bit per cycle. The upper half of the
// dividend must be below the divisor so the quotient fits. Uses bvf_pkg.
module bvf_div import bvf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  dividend,
    input  logic [ROOT_W-1:0] divisor,
    output unit_stat_t        stat,
    output logic [ROOT_W-1:0] quotient
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [SCNT_W-1:0]   cnt_reg, cnt_next;
    logic [ROOT_W-1:0]   dvs_reg;
    logic [ROOT_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   dq_reg;
    logic [ROOT_W:0]     rem_sh;
    logic                ge;

    // one trial subtract
    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[ROOT_W-1]};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        rem_next = ge ? ROOT_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[ROOT_W-1:0];
    end

    // step counter
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = SCNT_W'(ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // remainder, and low dividend bits that turn into the quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            rem_reg <= dividend[RAD_W-1:ROOT_W];
            dq_reg  <= dividend[ROOT_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= {dq_reg[ROOT_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dq_reg;

endmodule

// ===== design/body_velocity_friction_step_core.sv =====
// Top level of the body velocity/friction step core: sequencer, state and
// configuration registers. Uses bvf_pkg, bvf_mul, bvf_sqrt and bvf_div.
//
// A tick item (func = 0) works out gravity, squared speeds, friction cut,
// square root, friction scaling, division and position one after another
// on three bit-serial multiply lanes, a serial square root and two serial
// dividers, each pass started in a GO state and awaited in a WAIT state.
// A grounded body skips the gravity pass; zero speed or a cut larger than
// the speed skips the scaling and division passes. A set-ground item
// (func = 1) is handled in the idle state and gives no result. A new item is
// accepted only while the sequencer is idle, but a finished result sits in
// the output register and the next item may start before it is taken.
// Configuration is written with cfg_we/cfg_index/cfg_data at any time the
// core is idle; values are signed Q16.16 with saturating sums, the time
// step is Q0.16 and friction unsigned Q15.16.
module body_velocity_friction_step_core import bvf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [VAL_W-1:0]        cfg_data,
    // input items
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    func,
    input  logic [DT_W-1:0]         time_step,
    input  logic signed [VAL_W-1:0] pos_x,
    input  logic signed [VAL_W-1:0] pos_y,
    input  logic signed [VAL_W-1:0] pos_z,
    // result items
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] new_pos_x,
    output logic signed [VAL_W-1:0] new_pos_y,
    output logic signed [VAL_W-1:0] new_pos_z,
    output logic signed [VAL_W-1:0] vel_out_x,
    output logic signed [VAL_W-1:0] vel_out_y,
    output logic signed [VAL_W-1:0] vel_out_z
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GRAV_GO,
        ST_GRAV_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_FRIC_CHECK,
        ST_SCALE_GO,
        ST_SCALE_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_POS_GO,
        ST_POS_WAIT,
        ST_EMIT
    } state_t;

    state_t                  state_reg;

    // configuration registers
    logic signed [VAL_W-1:0] grav_x_reg, grav_y_reg, grav_z_reg;
    logic [FRIC_W-1:0]       fric_reg;

    // body state and item registers
    logic signed [VAL_W-1:0] vel_x_reg, vel_y_reg, vel_z_reg;
    logic                    grounded_reg;
    logic [DT_W-1:0]         dt_reg;
    logic signed [VAL_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [FRIC_W-1:0]       cut_reg;
    logic [ROOT_W-1:0]       speed_reg;

    // output register
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] new_pos_x_reg, new_pos_y_reg, new_pos_z_reg;
    logic signed [VAL_W-1:0] vel_out_x_reg, vel_out_y_reg, vel_out_z_reg;

    // unit connections
    mul_cmd_t                mx_cmd, my_cmd, mz_cmd;
    logic signed [MA_W-1:0]  mx_a, my_a, mz_a;
    logic [MB_W-1:0]         mx_b, my_b, mz_b;
    unit_stat_t              mx_st, my_st, mz_st, sq_st, dx_st, dz_st;
    logic signed [MP_W-1:0]  mx_prod, my_prod, mz_prod;
    logic [ROOT_W-1:0]       sq_root, dx_quo, dz_quo;
    logic                    sq_start, div_start;
    logic [RAD_W-1:0]        sq_rad;
    logic [MB_W-1:0]         dt_b;
    logic [VAL_W-1:0]        mag_x, mag_z;
    logic                    out_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign dt_b      = {dt_reg, {(MB_W-DT_W){1'b0}}};
    assign mag_x     = mag(vel_x_reg);
    assign mag_z     = mag(vel_z_reg);
    assign sq_start  = (state_reg == ST_SQRT_GO);
    assign div_start = (state_reg == ST_DIV_GO);
    assign sq_rad    = mx_prod[RAD_W-1:0] + mz_prod[RAD_W-1:0];
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // lane operands per phase
    always_comb
    begin
        mx_cmd = '0;
        my_cmd = '0;
        mz_cmd = '0;
        mx_a   = MA_W'(vel_x_reg);
        my_a   = MA_W'(vel_y_reg);
        mz_a   = MA_W'(vel_z_reg);
        mx_b   = dt_b;
        my_b   = dt_b;
        mz_b   = dt_b;
        unique case (state_reg)
            ST_GRAV_GO:
            begin
                mx_cmd.start = 1'b1;
                my_cmd.start = 1'b1;
                mz_cmd.start = 1'b1;
                mx_a         = MA_W'(grav_x_reg);
                my_a         = MA_W'(grav_y_reg);
                mz_a         = MA_W'(grav_z_reg);
            end
            ST_SQ_GO:
            begin
                mx_cmd = '{start: 1'b1, full: 1'b1};
                mz_cmd = '{start: 1'b1, full: 1'b1};
                my_cmd.start = 1'b1;
                mx_a   = {1'b0, mag_x};
                mz_a   = {1'b0, mag_z};
                mx_b   = mag_x;
                mz_b   = mag_z;
                my_a   = {2'b00, fric_reg};
            end
            ST_SCALE_GO:
            begin
                mx_cmd = '{start: 1'b1, full: 1'b1};
                mz_cmd = '{start: 1'b1, full: 1'b1};
                mx_a   = {2'b00, cut_reg};
                mz_a   = {2'b00, cut_reg};
                mx_b   = mag_x;
                mz_b   = mag_z;
            end
            ST_POS_GO:
            begin
                mx_cmd.start = 1'b1;
                my_cmd.start = 1'b1;
                mz_cmd.start = 1'b1;
            end
            default:
            begin
                mx_cmd = '0;
            end
        endcase
    end

    // multiply lanes
    bvf_mul u_mul_x (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mx_cmd),
        .a     (mx_a),
        .b     (mx_b),
        .stat  (mx_st),
        .prod  (mx_prod)
    );

    bvf_mul u_mul_y (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (my_cmd),
        .a     (my_a),
        .b     (my_b),
        .stat  (my_st),
        .prod  (my_prod)
    );

    bvf_mul u_mul_z (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mz_cmd),
        .a     (mz_a),
        .b     (mz_b),
        .stat  (mz_st),
        .prod  (mz_prod)
    );

    // horizontal speed
    bvf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .stat     (sq_st),
        .root     (sq_root)
    );

    // friction share of each component
    bvf_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mx_prod[RAD_W-1:0]),
        .divisor  (speed_reg),
        .stat     (dx_st),
        .quotient (dx_quo)
    );

    bvf_div u_div_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mz_prod[RAD_W-1:0]),
        .divisor  (speed_reg),
        .stat     (dz_st),
        .quotient (dz_quo)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_x_reg <= '0;
            grav_y_reg <= '0;
            grav_z_reg <= '0;
            fric_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRAVITY_X: grav_x_reg <= cfg_data;
                REG_GRAVITY_Y: grav_y_reg <= cfg_data;
                REG_GRAVITY_Z: grav_z_reg <= cfg_data;
                REG_FRICTION:  fric_reg   <= cfg_data[FRIC_W-1:0];
                default:       fric_reg   <= fric_reg;
            endcase
        end
    end

    // sequencer, body state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            vel_z_reg     <= '0;
            grounded_reg  <= 1'b0;
            dt_reg        <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            cut_reg       <= '0;
            speed_reg     <= '0;
            out_valid_reg <= 1'b0;
            new_pos_x_reg <= '0;
            new_pos_y_reg <= '0;
            new_pos_z_reg <= '0;
            vel_out_x_reg <= '0;
            vel_out_y_reg <= '0;
            vel_out_z_reg <= '0;
        end
        else
        begin
            // output handshake, a new result takes the register
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (func)
                        begin
                            grounded_reg <= 1'b1;
                            vel_y_reg    <= '0;
                        end
                        else
                        begin
                            dt_reg    <= time_step;
                            pos_x_reg <= pos_x;
                            pos_y_reg <= pos_y;
                            pos_z_reg <= pos_z;
                            state_reg <= grounded_reg ? ST_SQ_GO : ST_GRAV_GO;
                        end
                    end
                end
                ST_GRAV_GO:
                    state_reg <= ST_GRAV_WAIT;
                ST_GRAV_WAIT:
                begin
                    if (mx_st.done)
                    begin
                        vel_x_reg <= sat_add(vel_x_reg, mx_prod[FRAC_W +: VAL_W]);
                        vel_y_reg <= sat_add(vel_y_reg, my_prod[FRAC_W +: VAL_W]);
                        vel_z_reg <= sat_add(vel_z_reg, mz_prod[FRAC_W +: VAL_W]);
                        state_reg <= ST_SQ_GO;
                    end
                end
                ST_SQ_GO:
                    state_reg <= ST_SQ_WAIT;
                ST_SQ_WAIT:
                begin
                    // cut lane has only half the steps and is long done
                    if (mx_st.done)
                    begin
                        cut_reg   <= my_prod[FRAC_W +: FRIC_W];
                        state_reg <= ST_SQRT_GO;
                    end
                end
                ST_SQRT_GO:
                    state_reg <= ST_SQRT_WAIT;
                ST_SQRT_WAIT:
                begin
                    if (sq_st.done)
                    begin
                        speed_reg <= sq_root;
                        state_reg <= ST_FRIC_CHECK;
                    end
                end
                ST_FRIC_CHECK:
                begin
                    // no direction at zero speed; full stop when cut exceeds speed
                    if (speed_reg == '0)
                        state_reg <= ST_POS_GO;
                    else if (speed_reg < {1'b0, cut_reg})
                    begin
                        vel_x_reg <= '0;
                        vel_z_reg <= '0;
                        state_reg <= ST_POS_GO;
                    end
                    else
                        state_reg <= ST_SCALE_GO;
                end
                ST_SCALE_GO:
                    state_reg <= ST_SCALE_WAIT;
                ST_SCALE_WAIT:
                begin
                    if (mx_st.done)
                        state_reg <= ST_DIV_GO;
                end
                ST_DIV_GO:
                    state_reg <= ST_DIV_WAIT;
                ST_DIV_WAIT:
                begin
                    // magnitude moves toward zero
                    if (dx_st.done)
                    begin
                        vel_x_reg <= vel_x_reg[VAL_W-1] ? vel_x_reg + dx_quo
                                                        : vel_x_reg - dx_quo;
                        vel_z_reg <= vel_z_reg[VAL_W-1] ? vel_z_reg + dz_quo
                                                        : vel_z_reg - dz_quo;
                        state_reg <= ST_POS_GO;
                    end
                end
                ST_POS_GO:
                    state_reg <= ST_POS_WAIT;
                ST_POS_WAIT:
                begin
                    if (mx_st.done)
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        new_pos_x_reg <= sat_add(pos_x_reg, mx_prod[FRAC_W +: VAL_W]);
                        new_pos_y_reg <= sat_add(pos_y_reg, my_prod[FRAC_W +: VAL_W]);
                        new_pos_z_reg <= sat_add(pos_z_reg, mz_prod[FRAC_W +: VAL_W]);
                        vel_out_x_reg <= vel_x_reg;
                        vel_out_y_reg <= vel_y_reg;
                        vel_out_z_reg <= vel_z_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign new_pos_x = new_pos_x_reg;
    assign new_pos_y = new_pos_y_reg;
    assign new_pos_z = new_pos_z_reg;
    assign vel_out_x = vel_out_x_reg;
    assign vel_out_y = vel_out_y_reg;
    assign vel_out_z = vel_out_z_reg;

    // no serial unit still running while the core takes items
    a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(mx_st.busy || my_st.busy || mz_st.busy ||
                                     sq_st.busy || dx_st.busy || dz_st.busy))
        else $error("serial unit busy while core idle");

    // set-ground item leaves the body grounded with no vertical velocity
    a_ground_clears_vy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func) |=> (vel_y_reg == '0 && grounded_reg))
        else $error("set-ground item did not clear vertical velocity");

    // grounded is only cleared by reset
    a_grounded_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        grounded_reg |=> grounded_reg)
        else $error("grounded flag dropped");

    // horizontal lanes and dividers run in lockstep
    a_xz_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (mx_st.done || mz_st.done || dx_st.done || dz_st.done) |->
        (mx_st.done == mz_st.done && dx_st.done == dz_st.done))
        else $error("x and z units out of step");

    // a result loaded into the output register is offered next cycle
    a_emit_offers: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("emitted item not offered");

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for body_velocity_friction_step_core: tick and set-ground
// items in, each motion result predicted in-bench and compared field by field
// depends on bvf_pkg and the core rtl
module testbench;
    import bvf_pkg::*;

    // item functions
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_GROUND = 1'b1;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [DT_W-1:0] DT_FULL = '1;

    // cycles waited after the last result before a register write
    localparam int DRAIN_CYCLES = 250;
    localparam int QUIET_LIMIT  = 5000;

    typedef struct {
        logic signed [VAL_W-1:0] px;
        logic signed [VAL_W-1:0] py;
        logic signed [VAL_W-1:0] pz;
        logic signed [VAL_W-1:0] vx;
        logic signed [VAL_W-1:0] vy;
        logic signed [VAL_W-1:0] vz;
    } motion_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [VAL_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic                    func;
    logic [DT_W-1:0]         time_step;
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] pos_z;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [VAL_W-1:0] new_pos_x;
    logic signed [VAL_W-1:0] new_pos_y;
    logic signed [VAL_W-1:0] new_pos_z;
    logic signed [VAL_W-1:0] vel_out_x;
    logic signed [VAL_W-1:0] vel_out_y;
    logic signed [VAL_W-1:0] vel_out_z;

    // predicted body state and register copies
    logic signed [VAL_W-1:0] body_vx;
    logic signed [VAL_W-1:0] body_vy;
    logic signed [VAL_W-1:0] body_vz;
    bit                      body_grounded;
    logic signed [VAL_W-1:0] gravity_x_q;
    logic signed [VAL_W-1:0] gravity_y_q;
    logic signed [VAL_W-1:0] gravity_z_q;
    logic [FRIC_W-1:0]       friction_q;

    motion_t expected_motion[$];
    int errors       = 0;
    int send_pct     = 0;
    int recv_pct     = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;

    body_velocity_friction_step_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .time_step (time_step),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .new_pos_x (new_pos_x),
        .new_pos_y (new_pos_y),
        .new_pos_z (new_pos_z),
        .vel_out_x (vel_out_x),
        .vel_out_y (vel_out_y),
        .vel_out_z (vel_out_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // value times dt in q16.16, rounded toward minus infinity
    function automatic longint times_dt(input longint v, input logic [DT_W-1:0] dt);
        longint d;
        d = longint'(dt);
        return (v * d) >>> FRAC_W;
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_val(input longint v);
        if (v > longint'(VAL_MAX))
            return VAL_MAX;
        if (v < longint'(VAL_MIN))
            return VAL_MIN;
        return v[VAL_W-1:0];
    endfunction

    // exact floor square root, bit by bit
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem   = n;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe >>= 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    // component loses its share of the cut, magnitude moves toward zero
    function automatic logic signed [VAL_W-1:0] friction_scaled(
        input logic signed [VAL_W-1:0] v,
        input longint unsigned cut,
        input longint unsigned speed
    );
        longint          sv;
        longint unsigned m;
        longint unsigned d;
        sv = longint'(v);
        m  = (sv < 0) ? -sv : sv;
        d  = (cut * m) / speed;
        return (sv < 0) ? VAL_W'(sv + longint'(d)) : VAL_W'(sv - longint'(d));
    endfunction

    // advance the predicted body by one item, returns 1 when a result follows
    function automatic bit step_body(
        input  logic                    op,
        input  logic [DT_W-1:0]         dt,
        input  logic signed [VAL_W-1:0] px,
        input  logic signed [VAL_W-1:0] py,
        input  logic signed [VAL_W-1:0] pz,
        output motion_t                 m
    );
        longint          sx;
        longint          sz;
        longint unsigned ax;
        longint unsigned az;
        longint unsigned speed;
        longint unsigned fr;
        longint unsigned cut;
        m = '{default: '0};
        if (op == FUNC_GROUND)
        begin
            body_grounded = 1'b1;
            body_vy       = '0;
            return 1'b0;
        end
        // gravity only while airborne
        if (!body_grounded)
        begin
            body_vx = clamp_val(longint'(body_vx) + times_dt(longint'(gravity_x_q), dt));
            body_vy = clamp_val(longint'(body_vy) + times_dt(longint'(gravity_y_q), dt));
            body_vz = clamp_val(longint'(body_vz) + times_dt(longint'(gravity_z_q), dt));
        end
        // horizontal friction along the direction of motion
        sx    = longint'(body_vx);
        sz    = longint'(body_vz);
        ax    = (sx < 0) ? -sx : sx;
        az    = (sz < 0) ? -sz : sz;
        speed = floor_sqrt(ax * ax + az * az);
        fr    = longint'(friction_q);
        cut   = (fr * dt) >> FRAC_W;
        if (speed != 0)
        begin
            if (speed < cut)
            begin
                body_vx = '0;
                body_vz = '0;
            end
            else
            begin
                body_vx = friction_scaled(body_vx, cut, speed);
                body_vz = friction_scaled(body_vz, cut, speed);
            end
        end
        m.px = clamp_val(longint'(px) + times_dt(longint'(body_vx), dt));
        m.py = clamp_val(longint'(py) + times_dt(longint'(body_vy), dt));
        m.pz = clamp_val(longint'(pz) + times_dt(longint'(body_vz), dt));
        m.vx = body_vx;
        m.vy = body_vy;
        m.vz = body_vz;
        return 1'b1;
    endfunction

    function automatic void compare_field(
        input string                   name,
        input logic signed [VAL_W-1:0] want,
        input logic signed [VAL_W-1:0] got
    );
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] opposing(input logic signed [VAL_W-1:0] v);
        return (v == VAL_MIN) ? VAL_MAX : -v;
    endfunction

    // signed value within about +-2^scale, any 32-bit value for large scales
    function automatic logic [VAL_W-1:0] rand_bounded(input int scale);
        if (scale > 24)
            return $urandom();
        return VAL_W'($urandom_range(2 << scale, 0)) - VAL_W'(1 << scale);
    endfunction

    // friction write data, bit 31 random since the register drops it
    function automatic logic [VAL_W-1:0] rand_friction(input int scale);
        logic [VAL_W-1:0] f;
        f[FRIC_W-1:0] = FRIC_W'((scale > 24) ? $urandom() : $urandom_range(1 << scale, 0));
        f[VAL_W-1]    = 1'($urandom_range(1, 0));
        if ($urandom_range(5, 0) == 0)
            f[FRIC_W-1:0] = '0;
        return f;
    endfunction

    function automatic logic [DT_W-1:0] rand_dt();
        return DT_W'(($urandom_range(3, 0) == 0) ? $urandom_range(1023, 0)
                                                 : $urandom_range(65535, 0));
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_pos();
        if ($urandom_range(4, 0) == 0)
            return $urandom();
        return VAL_W'($urandom_range(1 << 25, 0)) - VAL_W'(1 << 24);
    endfunction

    // send one item, predict its result, then maybe leave a gap
    task automatic send_item(
        input logic                    op,
        input logic [DT_W-1:0]         dt,
        input logic signed [VAL_W-1:0] px,
        input logic signed [VAL_W-1:0] py,
        input logic signed [VAL_W-1:0] pz
    );
        motion_t m;
        in_valid  <= 1'b1;
        func      <= op;
        time_step <= dt;
        pos_x     <= px;
        pos_y     <= py;
        pos_z     <= pz;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        if (step_body(op, dt, px, py, pz, m))
            expected_motion.push_back(m);
        if (send_pct != 0 && $urandom_range(99, 0) < send_pct)
        begin
            in_valid <= 1'b0;
            repeat (($urandom_range(15, 0) == 0) ? $urandom_range(250, 20) : $urandom_range(3, 1))
                @(posedge clk);
        end
    endtask

    // all results in, then room for a set-ground item still in flight
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_motion.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_GRAVITY_X: gravity_x_q = data;
            REG_GRAVITY_Y: gravity_y_q = data;
            REG_GRAVITY_Z: gravity_z_q = data;
            REG_FRICTION:  friction_q  = data[FRIC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(
        input logic [VAL_W-1:0] gx,
        input logic [VAL_W-1:0] gy,
        input logic [VAL_W-1:0] gz,
        input logic [VAL_W-1:0] fr
    );
        write_reg(REG_GRAVITY_X, gx);
        write_reg(REG_GRAVITY_Y, gy);
        write_reg(REG_GRAVITY_Z, gz);
        write_reg(REG_FRICTION, fr);
        cfg_we <= 1'b0;
    endtask

    // one full-length tick against the current velocity brings it near zero
    task automatic settle_velocity();
        wait_idle();
        load_config(opposing(body_vx), opposing(body_vy), opposing(body_vz), '0);
        send_item(FUNC_TICK, DT_FULL, '0, '0, '0);
    endtask

    task automatic test_free_directed();
        send_pct = 38;
        recv_pct = 53;
        // body at rest, zero horizontal speed
        load_config('0, '0, '0, '0);
        send_item(FUNC_TICK, '0, '0, '0, '0);
        send_item(FUNC_TICK, DT_FULL, VAL_MAX, VAL_MIN, VAL_MAX);
        // extreme gravity saturates velocity and positions
        wait_idle();
        load_config(VAL_MAX, VAL_MIN, VAL_MAX, '0);
        send_item(FUNC_TICK, DT_FULL, VAL_MAX, VAL_MIN, '0);
        send_item(FUNC_TICK, DT_FULL, VAL_MAX, VAL_MIN, VAL_MAX);
        send_item(FUNC_TICK, 16'd1, -32'sd1, 32'sd1, VAL_MIN);
        // full friction: scaled cut, then cut above speed, then zero speed
        wait_idle();
        load_config('0, '0, '0, '1);
        send_item(FUNC_TICK, DT_FULL, VAL_MIN, VAL_MAX, VAL_MIN);
        send_item(FUNC_TICK, DT_FULL, '0, '0, '0);
        send_item(FUNC_TICK, DT_FULL, 32'sd1, -32'sd1, 32'sd1);
        // moderate gravity and friction from near rest
        settle_velocity();
        wait_idle();
        load_config(32'hFFFD_0000, 32'hFFF6_0000, 32'h0002_0000, 32'h0000_8000);
        send_item(FUNC_TICK, 16'h8000, VAL_MIN, VAL_MAX, -32'sd1);
        send_item(FUNC_TICK, 16'h4000, 32'sd1, VAL_MIN, VAL_MAX);
    endtask

    task automatic test_free_random();
        for (int phase = 0; phase < 3; phase++)
        begin
            send_pct = (phase == 0) ? 38 : (phase == 1) ? 53 : 0;
            recv_pct = (phase == 0) ? 53 : (phase == 1) ? 38 : 0;
            settle_velocity();
            for (int blk = 0; blk < 5; blk++)
            begin
                int scale;
                scale = ($urandom_range(4, 0) == 0) ? 31 : $urandom_range(24, 8);
                wait_idle();
                load_config(rand_bounded(scale), rand_bounded(scale), rand_bounded(scale),
                            rand_friction(scale));
                repeat (100)
                    send_item(FUNC_TICK, rand_dt(), rand_pos(), rand_pos(), rand_pos());
            end
        end
    endtask

    task automatic test_grounding();
        send_pct = 0;
        recv_pct = 0;
        // build up horizontal speed while airborne
        settle_velocity();
        wait_idle();
        load_config(32'h1000_0000, 32'hFC00_0000, 32'hF800_0000, '0);
        send_item(FUNC_TICK, DT_FULL, rand_pos(), rand_pos(), rand_pos());
        // set-ground ignores its payload, gravity is skipped from then on
        send_item(FUNC_GROUND, rand_dt(), rand_pos(), rand_pos(), rand_pos());
        send_item(FUNC_TICK, 16'h8000, '0, '0, '0);
        send_item(FUNC_GROUND, DT_FULL, VAL_MIN, VAL_MAX, VAL_MIN);
        send_item(FUNC_TICK, DT_FULL, VAL_MAX, VAL_MIN, VAL_MAX);
    endtask

    task automatic test_grounded_random();
        for (int blk = 0; blk < 4; blk++)
        begin
            logic [VAL_W-1:0] fr;
            fr[VAL_W-1]    = 1'($urandom_range(1, 0));
            fr[FRIC_W-1:0] = FRIC_W'((blk < 3) ? $urandom_range(4095, 0) : $urandom());
            wait_idle();
            load_config($urandom(), $urandom(), $urandom(), fr);
            repeat (100)
                send_item(($urandom_range(6, 0) == 0) ? FUNC_GROUND : FUNC_TICK,
                          rand_dt(), rand_pos(), rand_pos(), rand_pos());
        end
    endtask

    // receiver stalls, short and now and then long
    always @(posedge clk)
    begin : ready_drive
        bit rdy;
        if (stall_left > 0)
        begin
            stall_left--;
            rdy = 1'b0;
        end
        else if (recv_pct != 0 && $urandom_range(2047, 0) == 0)
        begin
            stall_left = $urandom_range(300, 20);
            rdy        = 1'b0;
        end
        else
            rdy = ($urandom_range(99, 0) >= recv_pct);
        out_ready <= rdy;
    end

    // compare each result item with the oldest prediction
    always @(posedge clk)
    begin : result_check
        motion_t want;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (expected_motion.size() == 0)
            begin
                $error("result item with no prediction pending");
                errors++;
            end
            else
            begin
                want = expected_motion.pop_front();
                compare_field("new_pos_x", want.px, new_pos_x);
                compare_field("new_pos_y", want.py, new_pos_y);
                compare_field("new_pos_z", want.pz, new_pos_z);
                compare_field("vel_out_x", want.vx, vel_out_x);
                compare_field("vel_out_y", want.vy, vel_out_y);
                compare_field("vel_out_z", want.vz, vel_out_z);
            end
        end
    end

    // watchdog on cycles without any handshake or write
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        func          = FUNC_TICK;
        time_step     = '0;
        pos_x         = '0;
        pos_y         = '0;
        pos_z         = '0;
        out_ready     = 1'b0;
        body_vx       = '0;
        body_vy       = '0;
        body_vz       = '0;
        body_grounded = 1'b0;
        gravity_x_q   = '0;
        gravity_y_q   = '0;
        gravity_z_q   = '0;
        friction_q    = '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_free_directed();
        test_free_random();
        test_grounding();
        test_grounded_random();
        wait_idle();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== body_velocity_friction_step_core.f =====
design/bvf_pkg.sv
design/bvf_mul.sv
design/bvf_sqrt.sv
design/bvf_div.sv
design/body_velocity_friction_step_core.sv
bench/testbench.sv
